// ===== rtl/bp_pkg.sv =====
// bp_pkg: word types, status codes and fixed widths for the parabola breakpoint block
// depends on nothing; imported by parabola_breakpoint
package bp_pkg;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] sweep_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         status;
  } result_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG_DISC = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // root of a product below 2^129, radicand, signed x numerator
  localparam int ROOT_W = 65;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int NUM_W  = 67;
  // divisor widths: |e| <= 2^32, |2d| <= 2^33
  localparam int XD_W   = 33;
  localparam int YD_W   = 34;
  localparam int Q_W    = 32;

endpackage

// ===== rtl/bp_sqrt_cell.sv =====
// bp_sqrt_cell: one digit-by-digit square root step, one root bit per cell
// standalone; chained by parabola_breakpoint
module bp_sqrt_cell #(
  parameter int RW = 65,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  logic [2*RW-1:0] in_rad,
  input  logic [RW+1:0]   in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [SW-1:0]   in_side,
  output logic            out_v,
  output logic [2*RW-1:0] out_rad,
  output logic [RW+1:0]   out_rem,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic          ge;

  // remainder stays below 2*root+1, so its top two bits are zero here
  assign rem_sh = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
  assign trial  = {in_root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[2*RW-3:0], 2'b00};
      out_rem  <= ge ? (rem_sh - trial) : rem_sh;
      out_root <= {in_root[RW-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/bp_div_cell.sv =====
// bp_div_cell: one restoring division step, one quotient bit per cell
// standalone; chained by parabola_breakpoint
module bp_div_cell #(
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_nq,
  input  logic [DW-1:0] in_d,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [DW-1:0] out_rem,
  output logic [QW-1:0] out_nq,
  output logic [DW-1:0] out_d,
  output logic [SW-1:0] out_side
);

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  // numerator bits leave the top of nq while quotient bits enter the bottom
  assign rem_sh = {in_rem, in_nq[QW-1]};
  assign diff   = rem_sh - {1'b0, in_d};
  assign ge     = (rem_sh >= {1'b0, in_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      out_nq   <= {in_nq[QW-2:0], ge};
      out_d    <= in_d;
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/parabola_breakpoint.sv =====
// parabola_breakpoint: beach-line breakpoint of two parabolas, fully pipelined
// one word per cycle while the output register is empty or being taken
// the chain is 65 square-root cells, 32 x-divide cells and 32 y-divide cells plus 14 stages
// the whole chain advances when the output register is empty or taken; the input
// register also fills while the output waits, so one word is taken during a stall
// synchronous reset clears all valid bits and min_y; payload registers are not reset
module parabola_breakpoint (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bp_pkg::item_t     item,
  output logic              result_valid,
  input  logic              result_ready,
  output bp_pkg::result_t   result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  import bp_pkg::*;

  // case of the breakpoint, decided from the heights
  localparam logic [2:0] KIND_EQ  = 3'd0; // equal site heights
  localparam logic [2:0] KIND_RON = 3'd1; // right site on sweep line
  localparam logic [2:0] KIND_LON = 3'd2; // left site on sweep line
  localparam logic [2:0] KIND_NEG = 3'd3; // negative discriminant
  localparam logic [2:0] KIND_GEN = 3'd4; // quadratic root

  typedef struct packed {
    item_t                   w;
    logic [2:0]              kind;
    logic signed [NUM_W-1:0] num0;
    logic signed [32:0]      e;
  } sq_side_t;

  typedef struct packed {
    item_t      w;
    logic [2:0] kind;
    logic       neg;
    logic       ovf;
  } xd_side_t;

  typedef struct packed {
    logic        negd;
    logic        use_min;
    logic [31:0] xv;
    logic        satx;
    logic        neg;
    logic        ovf;
  } yd_side_t;

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int XD_SW = $bits(xd_side_t);
  localparam int YD_SW = $bits(yd_side_t);

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    return {v[31], v};
  endfunction

  // floor-rounded signed quotient from magnitudes, saturated; returns {sat, value}
  function automatic logic [32:0] fix_quot(input logic [31:0] q, input logic rnz,
                                           input logic neg, input logic ovf);
    logic [32:0] mag;
    logic [31:0] mneg;
    mag  = {1'b0, q} + {32'd0, rnz};
    mneg = ~mag[31:0] + 32'd1;
    if (ovf) begin
      return {1'b1, neg ? Q_MIN : Q_MAX};
    end else if (!neg) begin
      return q[31] ? {1'b1, Q_MAX} : {1'b0, q};
    end else if (mag > {1'b0, Q_MIN}) begin
      return {1'b1, Q_MIN};
    end else begin
      return {1'b0, mneg};
    end
  endfunction

  // configuration register; write it only while the block is idle (the block does not enforce this)
  logic [31:0] min_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_y <= '0;
    end else if (cfg_valid) begin
      min_y <= cfg_data;
    end
  end

  // global advance: the output register is empty or being taken
  logic adv;
  assign adv        = !result_valid || result_ready;

  // ---------------- stage 0: input register
  logic  s0_v;
  item_t s0_w;

  assign item_ready = adv || !s0_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (item_ready) begin
      s0_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      s0_w <= item;
    end
  end

  // ---------------- stage 1: height differences and case
  logic               s1_v;
  item_t              s1_w;
  logic [2:0]         s1_kind;
  logic signed [32:0] s1_d1, s1_d2, s1_e, s1_dxs;
  logic signed [32:0] d1_next, d2_next;
  logic [2:0]         kind_next;

  assign d1_next = sx33(s0_w.left_y) - sx33(s0_w.sweep_y);
  assign d2_next = sx33(s0_w.right_y) - sx33(s0_w.sweep_y);

  always_comb begin
    if (s0_w.left_y == s0_w.right_y) begin
      kind_next = KIND_EQ;
    end else if (s0_w.right_y == s0_w.sweep_y) begin
      kind_next = KIND_RON;
    end else if (s0_w.left_y == s0_w.sweep_y) begin
      kind_next = KIND_LON;
    end else if (d1_next[32] != d2_next[32]) begin
      // sites on opposite sides of the sweep line
      kind_next = KIND_NEG;
    end else begin
      kind_next = KIND_GEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_w    <= s0_w;
      s1_kind <= kind_next;
      s1_d1   <= d1_next;
      s1_d2   <= d2_next;
      s1_e    <= sx33(s0_w.right_y) - sx33(s0_w.left_y);
      s1_dxs  <= sx33(s0_w.left_x) - sx33(s0_w.right_x);
    end
  end

  // ---------------- stage 2: the five narrow products
  logic               s2_v;
  item_t              s2_w;
  logic [2:0]         s2_kind;
  logic signed [32:0] s2_e;
  logic signed [65:0] s2_m, s2_dx2, s2_e2, s2_pa, s2_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_w    <= s1_w;
      s2_kind <= s1_kind;
      s2_e    <= s1_e;
      s2_m    <= s1_d1 * s1_d2;
      s2_dx2  <= s1_dxs * s1_dxs;
      s2_e2   <= s1_e * s1_e;
      s2_pa   <= s1_d2 * sx33(s1_w.left_x);
      s2_pb   <= s1_d1 * sx33(s1_w.right_x);
    end
  end

  // ---------------- stage 3: d1*d2, squared distance, linear part of numerator
  logic                    s3_v;
  item_t                   s3_w;
  logic [2:0]              s3_kind;
  logic signed [32:0]      s3_e;
  logic [64:0]             s3_m;
  logic [65:0]             s3_len2;
  logic signed [NUM_W-1:0] s3_num0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_w    <= s2_w;
      s3_kind <= s2_kind;
      s3_e    <= s2_e;
      // product is non-negative whenever the root is used
      s3_m    <= s2_m[64:0];
      s3_len2 <= {1'b0, s2_dx2[64:0]} + {1'b0, s2_e2[64:0]};
      s3_num0 <= $signed({s2_pa[65], s2_pa}) - $signed({s2_pb[65], s2_pb});
    end
  end

  // ---------------- stage 4: radicand partial products
  logic        s4_v;
  sq_side_t    s4_side;
  logic [63:0] s4_pp0;
  logic [65:0] s4_pp1;
  logic [64:0] s4_pp2;
  logic [66:0] s4_pp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side.w    <= s3_w;
      s4_side.kind <= s3_kind;
      s4_side.num0 <= s3_num0;
      s4_side.e    <= s3_e;
      s4_pp0       <= s3_m[31:0] * s3_len2[31:0];
      s4_pp1       <= s3_m[31:0] * s3_len2[65:32];
      s4_pp2       <= s3_m[64:32] * s3_len2[31:0];
      s4_pp3       <= s3_m[64:32] * s3_len2[65:32];
    end
  end

  // ---------------- stage 5: middle partial products
  logic        s5_v;
  sq_side_t    s5_side;
  logic [63:0] s5_pp0;
  logic [66:0] s5_mid;
  logic [66:0] s5_pp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side <= s4_side;
      s5_pp0  <= s4_pp0;
      s5_mid  <= {1'b0, s4_pp1} + {2'b00, s4_pp2};
      s5_pp3  <= s4_pp3;
    end
  end

  // ---------------- stage 6 and square root chain
  logic             sq_v    [0:ROOT_W];
  logic [RAD_W-1:0] sq_rad  [0:ROOT_W];
  logic [ROOT_W+1:0] sq_rem [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root[0:ROOT_W];
  logic [SQ_SW-1:0] sq_side [0:ROOT_W];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= s5_side;
      sq_rad[0]  <= RAD_W'(s5_pp0) + (RAD_W'(s5_mid) << 32) + (RAD_W'(s5_pp3) << 64);
    end
  end

  genvar gi;
  for (gi = 0; gi < ROOT_W; gi++) begin : g_sq
    bp_sqrt_cell #(.RW(ROOT_W), .SW(SQ_SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_v     (sq_v[gi]),
      .in_rad   (sq_rad[gi]),
      .in_rem   (sq_rem[gi]),
      .in_root  (sq_root[gi]),
      .in_side  (sq_side[gi]),
      .out_v    (sq_v[gi+1]),
      .out_rad  (sq_rad[gi+1]),
      .out_rem  (sq_rem[gi+1]),
      .out_root (sq_root[gi+1]),
      .out_side (sq_side[gi+1])
    );
  end

  // ---------------- stage 7: full x numerator
  sq_side_t                sq_out;
  logic                    s7_v;
  sq_side_t                s7_side;
  logic signed [NUM_W-1:0] s7_num;

  assign sq_out = sq_side[ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side <= sq_out;
      s7_num  <= sq_out.num0 - $signed({2'b00, sq_root[ROOT_W]});
    end
  end

  // ---------------- stage 8: magnitudes, overflow precheck, x divide chain
  logic [NUM_W-1:0] xnum_neg;
  logic [NUM_W-2:0] xnum_mag;
  logic [32:0]      xe_neg;
  logic [XD_W-1:0]  xe_mag;
  xd_side_t         xd_in;

  assign xnum_neg = -s7_num;
  assign xnum_mag = s7_num[NUM_W-1] ? xnum_neg[NUM_W-2:0] : s7_num[NUM_W-2:0];
  assign xe_neg   = -s7_side.e;
  assign xe_mag   = s7_side.e[32] ? xe_neg : s7_side.e;

  always_comb begin
    xd_in.w    = s7_side.w;
    xd_in.kind = s7_side.kind;
    xd_in.neg  = s7_num[NUM_W-1] ^ s7_side.e[32];
    // quotient of 2^32 or more saturates whatever the sign
    xd_in.ovf  = (xnum_mag[NUM_W-2:Q_W] >= {1'b0, xe_mag});
  end

  logic            xd_v   [0:Q_W];
  logic [XD_W-1:0] xd_rem [0:Q_W];
  logic [Q_W-1:0]  xd_nq  [0:Q_W];
  logic [XD_W-1:0] xd_d   [0:Q_W];
  logic [XD_SW-1:0] xd_side[0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      xd_v[0] <= 1'b0;
    end else if (adv) begin
      xd_v[0] <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xd_rem[0]  <= xnum_mag[Q_W+XD_W-1:Q_W];
      xd_nq[0]   <= xnum_mag[Q_W-1:0];
      xd_d[0]    <= xe_mag;
      xd_side[0] <= xd_in;
    end
  end

  for (gi = 0; gi < Q_W; gi++) begin : g_xd
    bp_div_cell #(.DW(XD_W), .QW(Q_W), .SW(XD_SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_v     (xd_v[gi]),
      .in_rem   (xd_rem[gi]),
      .in_nq    (xd_nq[gi]),
      .in_d     (xd_d[gi]),
      .in_side  (xd_side[gi]),
      .out_v    (xd_v[gi+1]),
      .out_rem  (xd_rem[gi+1]),
      .out_nq   (xd_nq[gi+1]),
      .out_d    (xd_d[gi+1]),
      .out_side (xd_side[gi+1])
    );
  end

  // ---------------- stage 9: x per case, saturated
  xd_side_t    xd_out;
  logic [32:0] xq_fix;
  logic [32:0] xsum;
  logic [31:0] xv_next;
  logic        satx_next;
  logic        s9_v;
  item_t       s9_w;
  logic [2:0]  s9_kind;
  logic [31:0] s9_xv;
  logic        s9_satx;

  assign xd_out = xd_side[Q_W];
  assign xq_fix = fix_quot(xd_nq[Q_W], |xd_rem[Q_W], xd_out.neg, xd_out.ovf);
  assign xsum   = sx33(xd_out.w.left_x) + sx33(xd_out.w.right_x);

  always_comb begin
    xv_next   = xq_fix[31:0];
    satx_next = xq_fix[32];
    case (xd_out.kind)
      KIND_EQ: begin
        // floor of the midpoint always fits
        xv_next   = xsum[32:1];
        satx_next = 1'b0;
      end
      KIND_RON: begin
        xv_next   = xd_out.w.right_x;
        satx_next = 1'b0;
      end
      KIND_LON: begin
        xv_next   = xd_out.w.left_x;
        satx_next = 1'b0;
      end
      KIND_NEG: begin
        xv_next   = Q_MAX;
        satx_next = 1'b0;
      end
      default: begin
        xv_next   = xq_fix[31:0];
        satx_next = xq_fix[32];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v <= xd_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_w    <= xd_out.w;
      s9_kind <= xd_out.kind;
      s9_xv   <= xv_next;
      s9_satx <= satx_next;
    end
  end

  // ---------------- stage 10: site for y and its differences
  logic [31:0]        qx, qy;
  logic               s10_v;
  yd_side_t           s10_side;
  logic signed [32:0] s10_d, s10_dx, s10_t;

  // the right site gives y only when the left one sits on the sweep line
  assign qx = (s9_kind == KIND_LON) ? s9_w.right_x : s9_w.left_x;
  assign qy = (s9_kind == KIND_LON) ? s9_w.right_y : s9_w.left_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (adv) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_side.negd    <= (s9_kind == KIND_NEG);
      s10_side.use_min <= (qy == s9_w.sweep_y);
      s10_side.xv      <= s9_xv;
      s10_side.satx    <= s9_satx;
      s10_side.neg     <= 1'b0;
      s10_side.ovf     <= 1'b0;
      s10_d            <= sx33(qy) - sx33(s9_w.sweep_y);
      s10_dx           <= sx33(qx) - sx33(s9_xv);
      s10_t            <= sx33(qy) + sx33(s9_w.sweep_y);
    end
  end

  // ---------------- stage 11: y products
  logic               s11_v;
  yd_side_t           s11_side;
  logic signed [65:0] s11_dx2, s11_dt;
  logic signed [33:0] s11_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (adv) begin
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_side <= s10_side;
      s11_dx2  <= s10_dx * s10_dx;
      s11_dt   <= s10_d * s10_t;
      s11_den  <= {s10_d, 1'b0};
    end
  end

  // ---------------- stage 12: y numerator
  logic                    s12_v;
  yd_side_t                s12_side;
  logic signed [NUM_W-1:0] s12_n;
  logic signed [33:0]      s12_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_v <= 1'b0;
    end else if (adv) begin
      s12_v <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_side <= s11_side;
      s12_n    <= $signed({s11_dx2[65], s11_dx2}) + $signed({s11_dt[65], s11_dt});
      s12_den  <= s11_den;
    end
  end

  // ---------------- stage 13: magnitudes, precheck, y divide chain
  logic [NUM_W-1:0] ynum_neg;
  logic [NUM_W-2:0] ynum_mag;
  logic [YD_W-1:0]  yden_neg;
  logic [YD_W-1:0]  yden_mag;
  yd_side_t         yd_in;

  assign ynum_neg = -s12_n;
  assign ynum_mag = s12_n[NUM_W-1] ? ynum_neg[NUM_W-2:0] : s12_n[NUM_W-2:0];
  assign yden_neg = -s12_den;
  assign yden_mag = s12_den[YD_W-1] ? yden_neg : s12_den;

  always_comb begin
    yd_in     = s12_side;
    yd_in.neg = s12_n[NUM_W-1] ^ s12_den[YD_W-1];
    yd_in.ovf = (ynum_mag[NUM_W-2:Q_W] >= yden_mag);
  end

  logic            yd_v   [0:Q_W];
  logic [YD_W-1:0] yd_rem [0:Q_W];
  logic [Q_W-1:0]  yd_nq  [0:Q_W];
  logic [YD_W-1:0] yd_d   [0:Q_W];
  logic [YD_SW-1:0] yd_side[0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      yd_v[0] <= 1'b0;
    end else if (adv) begin
      yd_v[0] <= s12_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yd_rem[0]  <= ynum_mag[Q_W+YD_W-1:Q_W];
      yd_nq[0]   <= ynum_mag[Q_W-1:0];
      yd_d[0]    <= yden_mag;
      yd_side[0] <= yd_in;
    end
  end

  for (gi = 0; gi < Q_W; gi++) begin : g_yd
    bp_div_cell #(.DW(YD_W), .QW(Q_W), .SW(YD_SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_v     (yd_v[gi]),
      .in_rem   (yd_rem[gi]),
      .in_nq    (yd_nq[gi]),
      .in_d     (yd_d[gi]),
      .in_side  (yd_side[gi]),
      .out_v    (yd_v[gi+1]),
      .out_rem  (yd_rem[gi+1]),
      .out_nq   (yd_nq[gi+1]),
      .out_d    (yd_d[gi+1]),
      .out_side (yd_side[gi+1])
    );
  end

  // ---------------- output register
  yd_side_t    yd_out;
  logic [32:0] yq_fix;
  result_t     result_next;
  logic        saty;

  assign yd_out = yd_side[Q_W];
  assign yq_fix = fix_quot(yd_nq[Q_W], |yd_rem[Q_W], yd_out.neg, yd_out.ovf);
  assign saty   = !yd_out.use_min && yq_fix[32];

  always_comb begin
    if (yd_out.negd) begin
      result_next.point_x = Q_MAX;
      result_next.point_y = Q_MAX;
      result_next.status  = ST_NEG_DISC;
    end else begin
      result_next.point_x = yd_out.xv;
      // site on the sweep line: y is the configured floor
      result_next.point_y = yd_out.use_min ? min_y : yq_fix[31:0];
      result_next.status  = (yd_out.satx || saty) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= yd_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  // ---------------- checks
  a_neg_disc_sat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_NEG_DISC) |->
      (result.point_x == Q_MAX && result.point_y == Q_MAX))
    else $error("negative discriminant word without saturated point");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.status == ST_OK || result.status == ST_NEG_DISC || result.status == ST_SAT))
    else $error("undefined status code");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s0_v && result_valid && !result_ready))
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word valid right after reset");

endmodule

// ===== tb/sv/tb_parabola_breakpoint.sv =====
// testbench for parabola_breakpoint: directed and random site pairs against a local model
// depends on bp_pkg and the parabola_breakpoint rtl
`timescale 1ns / 100ps

module tb_parabola_breakpoint;
  import bp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // pipeline depth given for the block
  localparam int LATENCY = 143;
  // room for the square of a 128-bit root candidate plus sign
  localparam int WIDE = 264;
  typedef logic signed [WIDE-1:0] wide_t;

  parabola_breakpoint dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_t pending_items[$];
  result_t expected_points[$];
  logic signed [31:0] min_y_model = '0;
  int mismatches = 0;
  int words_checked = 0;
  int sat_count = 0;
  int neg_disc_count = 0;
  bit hold_results = 1'b0;

  // floor division on wide signed values
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // floor square root, bit by bit over 128 result bits
  function automatic wide_t floor_sqrt(wide_t n);
    wide_t r, c;
    r = 0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // parabola of site q at the clamped x
  function automatic wide_t arc_height(wide_t qx, wide_t qy, wide_t s, wide_t x);
    wide_t d;
    d = qy - s;
    return floor_div((qx - x) * (qx - x) + d * (qy + s), 2 * d);
  endfunction

  function automatic result_t predict_breakpoint(item_t it);
    wide_t px, py, rx, ry, s, qx, qy, x, d1, d2, e, len2, root;
    logic signed [31:0] xv;
    bit sat;
    result_t r;
    px = it.left_x; py = it.left_y; rx = it.right_x; ry = it.right_y;
    s = it.sweep_y;
    qx = px; qy = py; sat = 1'b0;
    if (py == ry) begin
      x = floor_div(px + rx, 2);
    end else if (ry == s) begin
      x = rx;
    end else if (py == s) begin
      x = px; qx = rx; qy = ry;
    end else begin
      d1 = py - s; d2 = ry - s; e = ry - py;
      if ((d1 < 0) != (d2 < 0)) begin
        r.point_x = Q_MAX;
        r.point_y = Q_MAX;
        r.status = ST_NEG_DISC;
        return r;
      end
      len2 = (px - rx) * (px - rx) + e * e;
      root = floor_sqrt(d1 * d2 * len2);
      x = floor_div(d2 * px - d1 * rx - root, e);
    end
    xv = clamp32(x, sat);
    r.point_x = xv;
    if (qy != s) r.point_y = clamp32(arc_height(qx, qy, s, wide_t'(xv)), sat);
    else r.point_y = min_y_model;
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // sender: each word waits a random gap, counted down in send_gap, before it is offered
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        expected_points.push_back(predict_breakpoint(item));
        send_gap = $urandom_range(7);
        if (send_gap == 0 && pending_items.size() > 0) begin
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end else if (!item_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          send_gap = $urandom_range(7);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off while hold_results is set
  int take_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (take_gap > 0) take_gap--;
      if (result_valid && result_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", result);
        end else begin
          result_t exp_r;
          exp_r = expected_points.pop_front();
          words_checked++;
          if (exp_r.status == ST_SAT) sat_count++;
          if (exp_r.status == ST_NEG_DISC) neg_disc_count++;
          if (result.point_x !== exp_r.point_x || result.point_y !== exp_r.point_y ||
              result.status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
                       exp_r.point_x, exp_r.point_y, exp_r.status,
                       result.point_x, result.point_y, result.status);
          end
        end
        take_gap = $urandom_range(7);
      end
      result_ready <= !hold_results && take_gap == 0;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(200)) - 100) <<< 16;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    logic [31:0] s;
    it.left_x = rand_coord();
    it.right_x = rand_coord();
    s = rand_coord();
    it.sweep_y = s;
    // mostly both sites on the same side of the sweep, as a real beach line has
    it.left_y = rand_coord();
    it.right_y = rand_coord();
    case ($urandom_range(9))
      0: it.right_y = it.left_y;
      1: it.right_y = s;
      2: it.left_y = s;
      3: begin it.left_y = s; it.right_y = s; end
      4, 5, 6: begin
        it.left_y = s + $urandom_range(2000000);
        it.right_y = s + $urandom_range(2000000);
        if ($signed(it.left_y) < $signed(s)) it.left_y = 32'h7FFF_FFFF;
        if ($signed(it.right_y) < $signed(s)) it.right_y = 32'h7FFF_FFFF;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic item_t mk(logic [31:0] lx, logic [31:0] ly, logic [31:0] rx,
                               logic [31:0] ry, logic [31:0] s);
    item_t it;
    it.left_x = lx; it.left_y = ly; it.right_x = rx; it.right_y = ry; it.sweep_y = s;
    return it;
  endfunction

  // write min_y with the block idle
  task automatic write_min_y(logic [31:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_y_model = v;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    logic [31:0] cfg_values[5];
    cfg_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_min_y(32'h8000_0000);

    // directed: equal heights, site on sweep, all on sweep, opposite sides, extremes
    pending_items.push_back(mk(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 0));
    pending_items.push_back(mk(32'h7FFF_FFFF, ONE, 32'h7FFF_FFFF, ONE, 0));
    pending_items.push_back(mk(32'h8000_0000, ONE, 32'h8000_0001, ONE, 0));
    pending_items.push_back(mk(ONE, 3 * ONE, 5 * ONE, 0, 0));
    pending_items.push_back(mk(ONE, 0, 5 * ONE, 3 * ONE, 0));
    pending_items.push_back(mk(ONE, 7, 5 * ONE, 7, 7));
    pending_items.push_back(mk(0, ONE, ONE, -ONE, 0));
    pending_items.push_back(mk(0, -ONE, ONE, ONE, 0));
    pending_items.push_back(mk(0, 2 * ONE, 4 * ONE, 3 * ONE, 0));
    pending_items.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                               32'h8000_0000));
    pending_items.push_back(mk(32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000));
    pending_items.push_back(mk(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_items.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000));
    pending_items.push_back(mk(0, 0, 0, 0, 0));
    pending_items.push_back(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, ONE, 0));
    drain();

    // random phases, one per min_y setting; the first holds results back for a while
    foreach (cfg_values[i]) begin
      write_min_y(cfg_values[i]);
      for (int n = 0; n < 350; n++) pending_items.push_back(rand_item());
      if (i == 0) begin
        hold_results = 1'b1;
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
      drain();
    end

    $display("checked %0d result words over %0d min_y settings", words_checked, 6);
    $display("saturated: %0d, negative discriminant: %0d", sat_count, neg_disc_count);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bp_pkg.sv
rtl/bp_sqrt_cell.sv
rtl/bp_div_cell.sv
rtl/parabola_breakpoint.sv
tb/sv/tb_parabola_breakpoint.sv
